/* hw/rtl/oahm_pkg.sv */
package oahm_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int KEY_W          = 32;
	localparam int VAL_W          = 32;
	localparam int CNT_W          = 9;
	localparam int ACT_W          = 3;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_ERASE  = 3'd1,
		ACT_FIND   = 3'd2,
		ACT_UPSERT = 3'd3,
		ACT_CLEAR  = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		MARK_EMPTY    = 2'd0,
		MARK_DELETED  = 2'd1,
		MARK_OCCUPIED = 2'd2
	} mark_t;

	typedef struct packed {
		mark_t            mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} slot_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/oahm_home.sv */
module oahm_home #(
	parameter int SLOT_COUNT = oahm_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [oahm_pkg::KEY_W-1:0]      key,
	output logic                            done,
	output logic [$clog2(SLOT_COUNT)-1:0]   home
);
	import oahm_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

	logic          done_q;
	logic [AW-1:0] r_q;

	assign done = done_q;
	assign home = r_q;

	generate
		if (IS_POW2) begin : g_pow2
			// 2^AW divides 2^32, so sign extension does not move the low bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					r_q <= key[AW-1:0];
				end
			end
		end else begin : g_rem
			localparam int STEPS = KEY_W / 2;
			localparam int SW    = $clog2(STEPS);
			localparam logic [AW+1:0] N1 = (AW+2)'(SLOT_COUNT);
			localparam logic [AW+1:0] N2 = (AW+2)'(2 * SLOT_COUNT);
			localparam logic [AW+1:0] N3 = (AW+2)'(3 * SLOT_COUNT);
			localparam logic [AW:0]   NF = (AW+1)'(SLOT_COUNT);
			// (2^64 - 2^32) mod N: the sign extension of a negative key
			localparam logic [63:0]   NEG_WIDE = 64'hFFFF_FFFF_0000_0000 % 64'(SLOT_COUNT);
			localparam logic [AW-1:0] NEG_OFF  = NEG_WIDE[AW-1:0];

			logic             run_q;
			logic             fix_q;
			logic             neg_q;
			logic [SW-1:0]    step_q;
			logic [KEY_W-1:0] sh_q;
			logic [AW+1:0]    t;
			logic [AW+1:0]    t_red;
			logic [AW:0]      f;
			logic [AW:0]      f_red;

			// two key bits per step, remainder kept below N
			always_comb begin
				t = {r_q, sh_q[KEY_W-1 -: 2]};
				if (t >= N3) begin
					t_red = t - N3;
				end else if (t >= N2) begin
					t_red = t - N2;
				end else if (t >= N1) begin
					t_red = t - N1;
				end else begin
					t_red = t;
				end
				f = neg_q ? ({1'b0, r_q} + {1'b0, NEG_OFF}) : {1'b0, r_q};
				f_red = (f >= NF) ? (f - NF) : f;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					fix_q  <= 1'b0;
					done_q <= 1'b0;
					step_q <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						run_q  <= 1'b1;
						step_q <= '0;
					end else if (run_q) begin
						step_q <= step_q + 1'b1;
						if (step_q == SW'(STEPS - 1)) begin
							run_q <= 1'b0;
							fix_q <= 1'b1;
						end
					end else if (fix_q) begin
						fix_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= key;
					neg_q <= key[KEY_W-1];
					r_q   <= '0;
				end else if (run_q) begin
					sh_q <= {sh_q[KEY_W-3:0], 2'b00};
					r_q  <= t_red[AW-1:0];
				end else if (fix_q) begin
					r_q <= f_red[AW-1:0];
				end
			end
		end
	endgenerate

endmodule

/* hw/rtl/open_addressing_hash_map.sv */
// Key-value map over a single table memory of SLOT_COUNT slots, linear probing
// from the home slot (the key modulo SLOT_COUNT). One request is handled at a
// time: the request is accepted, the home slot is computed, the slots are
// probed in turn, since the table read port gives one slot per cycle, and
// the result word is handed over. Clear sweeps the table, one slot a cycle.
// After reset the same clearing pass runs before the first request is taken.
// A result word may wait on out_stall while the next request is already
// being worked on. entry_count wraps modulo 512.
module open_addressing_hash_map #(
	parameter int SLOT_COUNT = oahm_pkg::SLOT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [oahm_pkg::ACT_W-1:0]        action,
	input  logic signed [oahm_pkg::KEY_W-1:0] key,
	input  logic signed [oahm_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              success,
	output logic                              found,
	output logic signed [oahm_pkg::VAL_W-1:0] value_out,
	output logic [oahm_pkg::CNT_W-1:0]        entry_count
);
	import oahm_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

	state_t state_q, state_d;

	act_t             act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    addr_nx;
	logic [AW-1:0]    cnt_q;
	logic             iss_on_q;
	logic             vld_s1;
	logic             last_s1;
	logic [AW-1:0]    addr_s1;
	slot_t            rd_s1;
	logic             free_ok_q;
	logic [AW-1:0]    free_addr_q;
	logic [CNT_W-1:0] count_q;
	logic             hash_go_q;

	logic             res_success_q;
	logic             res_found_q;
	logic [VAL_W-1:0] res_vout_q;

	logic             out_valid_q;
	logic             out_success_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_vout_q;
	logic [CNT_W-1:0] out_count_q;

	slot_t mem [SLOT_COUNT];

	logic             in_acc;
	logic             home_done;
	logic [AW-1:0]    home;
	logic             re;
	logic             we;
	logic [AW-1:0]    wa;
	slot_t            wd;
	logic             hit;
	logic             empty;
	logic             stop;
	logic             free_ok;
	logic [AW-1:0]    free_addr;
	logic             sweep_end;
	logic             out_load;
	logic             r_success;
	logic             r_found;
	logic [VAL_W-1:0] r_vout;
	logic [CNT_W-1:0] count_nx;

	oahm_home #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_go_q),
		.key   (key_q),
		.done  (home_done),
		.home  (home)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign success     = out_success_q;
	assign found       = out_found_q;
	assign value_out   = out_vout_q;
	assign entry_count = out_count_q;

	assign addr_nx   = (addr_q == LAST) ? '0 : addr_q + 1'b1;
	assign hit       = (rd_s1.mark == MARK_OCCUPIED) && (rd_s1.key == key_q);
	assign empty     = (rd_s1.mark == MARK_EMPTY);
	assign free_ok   = free_ok_q || (rd_s1.mark != MARK_OCCUPIED);
	assign free_addr = free_ok_q ? free_addr_q : addr_s1;
	assign sweep_end = (addr_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		re         = 1'b0;
		we         = 1'b0;
		wa         = addr_q;
		wd         = '{mark: MARK_EMPTY, key: '0, val: '0};
		stop       = 1'b0;
		out_load   = 1'b0;
		r_success  = 1'b0;
		r_found    = 1'b0;
		r_vout     = '0;
		count_nx   = count_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				we = 1'b1;
				if (sweep_end) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (action inside {ACT_INSERT, ACT_ERASE, ACT_FIND, ACT_UPSERT}) begin
						state_d = ST_HASH;
					end else if (action == ACT_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_HASH: begin
				if (home_done) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				re   = iss_on_q;
				stop = vld_s1 && (hit || empty || last_s1);
				if (stop) begin
					state_d = ST_DONE;
					r_found = hit;
					case (act_q)
						ACT_INSERT: begin
							if (!hit && free_ok) begin
								we        = 1'b1;
								wa        = free_addr;
								wd        = '{mark: MARK_OCCUPIED, key: key_q, val: val_q};
								count_nx  = count_q + 1'b1;
								r_success = 1'b1;
							end
						end
						ACT_ERASE: begin
							if (hit) begin
								we        = 1'b1;
								wa        = addr_s1;
								wd        = '{mark: MARK_DELETED, key: rd_s1.key, val: rd_s1.val};
								count_nx  = count_q - 1'b1;
								r_success = 1'b1;
							end
						end
						ACT_FIND: begin
							if (hit) begin
								r_vout = rd_s1.val;
							end
						end
						ACT_UPSERT: begin
							if (hit) begin
								we        = 1'b1;
								wa        = addr_s1;
								wd        = '{mark: MARK_OCCUPIED, key: key_q, val: val_q};
								r_vout    = rd_s1.val;
								r_success = 1'b1;
							end else begin
								r_vout = val_q;
								if (free_ok) begin
									we        = 1'b1;
									wa        = free_addr;
									wd        = '{mark: MARK_OCCUPIED, key: key_q, val: val_q};
									count_nx  = count_q + 1'b1;
									r_success = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// home computation starts the cycle after accept, when key_q holds the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_go_q <= 1'b0;
		end else begin
			hash_go_q <= (state_q == ST_IDLE) && (state_d == ST_HASH);
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			cnt_q     <= '0;
			iss_on_q  <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			free_ok_q <= 1'b0;
			count_q   <= '0;
		end else begin
			vld_s1 <= re && !stop;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					addr_q <= addr_nx;
					if (sweep_end) begin
						count_q <= '0;
					end
				end
				ST_IDLE: begin
					addr_q <= '0;
				end
				ST_HASH: begin
					addr_q    <= home;
					cnt_q     <= '0;
					iss_on_q  <= 1'b1;
					free_ok_q <= 1'b0;
				end
				ST_PROBE: begin
					if (re) begin
						addr_q  <= addr_nx;
						cnt_q   <= cnt_q + 1'b1;
						last_s1 <= (cnt_q == LAST);
						if (cnt_q == LAST) begin
							iss_on_q <= 1'b0;
						end
					end
					if (vld_s1) begin
						free_ok_q <= free_ok;
					end
					if (stop) begin
						iss_on_q <= 1'b0;
						count_q  <= count_nx;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= act_t'(action);
			key_q <= key;
			val_q <= value;
		end
		if (re) begin
			addr_s1 <= addr_q;
		end
		if (state_q == ST_PROBE && vld_s1) begin
			free_addr_q <= free_addr;
		end
		if (in_acc) begin
			res_success_q <= 1'b0;
			res_found_q   <= 1'b0;
			res_vout_q    <= '0;
		end else if (stop) begin
			res_success_q <= r_success;
			res_found_q   <= r_found;
			res_vout_q    <= r_vout;
		end else if (state_q == ST_CLEAR && sweep_end) begin
			res_success_q <= 1'b1;
		end
		if (out_load) begin
			out_success_q <= res_success_q;
			out_found_q   <= res_found_q;
			out_vout_q    <= res_vout_q;
			out_count_q   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
